// ===== design/scrypt_romix_salsa20_8_defines.svh =====
// Assertion macros used by the checker file
`ifndef SCRYPT_ROMIX_SALSA20_8_DEFINES_SVH
`define SCRYPT_ROMIX_SALSA20_8_DEFINES_SVH

// Implication checked on every rising clock edge outside reset
`define SRX_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define SRX_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/srx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srx_pkg
// Shared widths, constants and Salsa20 helpers for the ROMix block.
// ----------------------------------------------------------------------------
package srx_pkg;
    localparam int MAX_COST_LOG2 = 10;
    localparam int COST_W        = 4;
    localparam int WORD_W        = 32;
    localparam int BLK_WORDS     = 32;
    localparam int WIDX_W        = 5;
    localparam int ENT_W         = MAX_COST_LOG2;
    localparam int PAD_AW        = ENT_W + WIDX_W;
    localparam int PAD_DEPTH     = 1 << PAD_AW;
    localparam int DR_W          = 2;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [15:0]      half_t;

    // request between controller and Salsa core
    typedef struct packed {
        logic  start;
        half_t din;
    } core_req_t;

    typedef struct packed {
        logic  done;
        half_t dout;
    } core_rsp_t;

    function automatic word_t rotl(input word_t v, input int unsigned s);
        rotl = (v << s) | (v >> (WORD_W - s));
    endfunction

    // quarter round on four words
    function automatic logic [4*WORD_W-1:0] qr(input word_t a, input word_t b,
                                               input word_t c, input word_t d);
        word_t b1, c1, d1, a1;
        b1 = b ^ rotl(a + d, 7);
        c1 = c ^ rotl(b1 + a, 9);
        d1 = d ^ rotl(c1 + b1, 13);
        a1 = a ^ rotl(d1 + c1, 18);
        qr = {a1, b1, c1, d1};
    endfunction

    // one Salsa20 double round
    function automatic half_t dround(input half_t x);
        half_t y, z;
        y = x;
        {y[0], y[4], y[8], y[12]}  = qr(x[0], x[4], x[8], x[12]);
        {y[5], y[9], y[13], y[1]}  = qr(x[5], x[9], x[13], x[1]);
        {y[10], y[14], y[2], y[6]} = qr(x[10], x[14], x[2], x[6]);
        {y[15], y[3], y[7], y[11]} = qr(x[15], x[3], x[7], x[11]);
        z = y;
        {z[0], z[1], z[2], z[3]}     = qr(y[0], y[1], y[2], y[3]);
        {z[5], z[6], z[7], z[4]}     = qr(y[5], y[6], y[7], y[4]);
        {z[10], z[11], z[8], z[9]}   = qr(y[10], y[11], y[8], y[9]);
        {z[15], z[12], z[13], z[14]} = qr(y[15], y[12], y[13], y[14]);
        dround = z;
    endfunction
endpackage

// ===== design/scrypt_romix_salsa20_8.sv =====
`timescale 1ns / 1ps
// Sequence: after word 31, phase one runs N times (a 32-word store plus two core passes)
// and phase two N times (one priming read, a 32-word xor, two core passes), then
// 32 output words at one per cycle when result ready is high.
// A new block is taken only after its last output word; the pace is set by the serial
// scratchpad port moving one word per cycle and the Salsa core doing one double round per cycle.
// Reset: asynchronous active low; work block cleared, cost_log2 back to 10.
// ----------------------------------------------------------------------------
// scrypt_romix_salsa20_8
// ROMix (r=1) top level: word loader, scratchpad sequencer and output stream.
// ----------------------------------------------------------------------------
module scrypt_romix_salsa20_8 (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [srx_pkg::COST_W-1:0]   cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [31:0]                  data_word,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [31:0]                  result_word,
    output logic                         last_word
);
    import srx_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_STORE, S_MIX0, S_WAIT0, S_MIX1, S_WAIT1,
        S_RD, S_XOR, S_OUT
    } state_t;

    state_t               state_reg;
    logic [COST_W-1:0]    cost_reg;
    logic [ENT_W-1:0]     nmask_reg;
    logic [ENT_W:0]       iter_reg;
    logic                 phase_reg;
    logic [WIDX_W:0]      widx_reg;
    word_t [31:0]         blk_reg;
    logic [ENT_W-1:0]     ent_reg;

    logic                 pad_we;
    logic [PAD_AW-1:0]    pad_waddr, pad_raddr;
    word_t                pad_rdata;
    core_req_t            creq;
    core_rsp_t            crsp;
    logic [ENT_W:0]       n_full;
    logic [COST_W-1:0]    lg;

    srx_pad u_pad (.clk(clk), .we(pad_we), .waddr(pad_waddr), .wdata(blk_reg[widx_reg[4:0]]),
                   .raddr(pad_raddr), .rdata(pad_rdata));
    srx_core u_core (.clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp));

    assign lg     = (cost_reg > COST_W'(MAX_COST_LOG2)) ? COST_W'(MAX_COST_LOG2) : cost_reg;
    assign n_full = (ENT_W+1)'(1) << lg;

    assign in_ready    = (state_reg == S_LOAD);
    assign out_valid   = (state_reg == S_OUT);
    assign result_word = blk_reg[widx_reg[4:0]];
    assign last_word   = (widx_reg[4:0] == 5'd31);

    assign pad_we    = (state_reg == S_STORE);
    assign pad_waddr = {iter_reg[ENT_W-1:0], widx_reg[4:0]};
    assign pad_raddr = {ent_reg, widx_reg[4:0]};

    // start core on the proper half
    always_comb
    begin
        creq.start = (state_reg == S_MIX0) || (state_reg == S_MIX1);
        for (int i = 0; i < 16; i++)
            creq.din[i] = (state_reg == S_MIX0) ? (blk_reg[i] ^ blk_reg[16+i])
                                                : (blk_reg[16+i] ^ blk_reg[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cost_reg  <= COST_W'(10);
            nmask_reg <= '0;
            iter_reg  <= '0;
            phase_reg <= 1'b0;
            widx_reg  <= '0;
            ent_reg   <= '0;
            blk_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                cost_reg <= cfg_wdata;
            case (state_reg)
                // collect words
                S_LOAD:
                begin
                    if (in_valid)
                    begin
                        blk_reg[widx_reg[4:0]] <= data_word;
                        if (widx_reg[4:0] == 5'd31)
                        begin
                            widx_reg  <= '0;
                            iter_reg  <= '0;
                            phase_reg <= 1'b0;
                            nmask_reg <= ENT_W'(n_full - 1'b1);
                            state_reg <= S_STORE;
                        end
                        else
                            widx_reg <= widx_reg + 1'b1;
                    end
                end
                // copy block into entry
                S_STORE:
                begin
                    if (widx_reg[4:0] == 5'd31)
                    begin
                        widx_reg  <= '0;
                        state_reg <= S_MIX0;
                    end
                    else
                        widx_reg <= widx_reg + 1'b1;
                end
                S_MIX0: state_reg <= S_WAIT0;
                S_WAIT0:
                begin
                    if (crsp.done)
                    begin
                        for (int i = 0; i < 16; i++)
                            blk_reg[i] <= crsp.dout[i];
                        state_reg <= S_MIX1;
                    end
                end
                S_MIX1: state_reg <= S_WAIT1;
                S_WAIT1:
                begin
                    if (crsp.done)
                    begin
                        for (int i = 0; i < 16; i++)
                            blk_reg[16+i] <= crsp.dout[i];
                        widx_reg <= '0;
                        ent_reg  <= crsp.dout[0][ENT_W-1:0] & nmask_reg;
                        if (iter_reg[ENT_W-1:0] == nmask_reg)
                        begin
                            iter_reg <= '0;
                            if (phase_reg)
                                state_reg <= S_OUT;
                            else
                            begin
                                phase_reg <= 1'b1;
                                state_reg <= S_RD;
                            end
                        end
                        else
                        begin
                            iter_reg  <= iter_reg + 1'b1;
                            state_reg <= phase_reg ? S_RD : S_STORE;
                        end
                    end
                end
                // prime read of word 0
                S_RD:
                begin
                    widx_reg  <= widx_reg + 1'b1;
                    state_reg <= S_XOR;
                end
                // xor in one word per cycle, read ahead one
                S_XOR:
                begin
                    blk_reg[5'(widx_reg - 1'b1)] <= blk_reg[5'(widx_reg - 1'b1)] ^ pad_rdata;
                    if (widx_reg == (WIDX_W+1)'(32))
                    begin
                        widx_reg  <= '0;
                        state_reg <= S_MIX0;
                    end
                    else
                        widx_reg <= widx_reg + 1'b1;
                end
                // stream result
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        if (widx_reg[4:0] == 5'd31)
                        begin
                            widx_reg  <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                            widx_reg <= widx_reg + 1'b1;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end
endmodule

// ===== design/srx_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srx_core
// Salsa20/8 core: one double round per cycle, feed-forward add at the end.
// ----------------------------------------------------------------------------
module srx_core (
    input  logic               clk,
    input  logic               rst_n,
    input  srx_pkg::core_req_t req,
    output srx_pkg::core_rsp_t rsp
);
    import srx_pkg::*;

    half_t          x_reg, init_reg;
    logic [DR_W-1:0] cnt_reg;
    logic           busy_reg, done_reg;
    half_t          dr;

    assign dr = dround(x_reg);

    // iterate double rounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DR_W'(3))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // hold working words
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg    <= req.din;
            init_reg <= req.din;
        end
        else if (busy_reg)
        begin
            x_reg <= dr;
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        for (int i = 0; i < 16; i++)
            rsp.dout[i] = x_reg[i] + init_reg[i];
    end
endmodule

// ===== design/srx_pad.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srx_pad
// Scratchpad memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module srx_pad (
    input  logic                           clk,
    input  logic                           we,
    input  logic [srx_pkg::PAD_AW-1:0]     waddr,
    input  srx_pkg::word_t                 wdata,
    input  logic [srx_pkg::PAD_AW-1:0]     raddr,
    output srx_pkg::word_t                 rdata
);
    import srx_pkg::*;

    word_t mem [PAD_DEPTH];

    // write then registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== design/srx_checker.sv =====
`timescale 1ns / 1ps
`include "scrypt_romix_salsa20_8_defines.svh"
// ----------------------------------------------------------------------------
// srx_checker
// Port-level checks on request and result streams.
// ----------------------------------------------------------------------------
module srx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] result_word,
    input logic        last_word
);
    // no request taken while results are shown
    `SRX_ASSERT_IMPL(a_excl, clk, rst_n, out_valid, !in_ready, "ready while streaming")
    // stalled result holds
    `SRX_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready,
                     out_valid && $stable(result_word), "result changed under stall")
    // after last word the stream ends
    `SRX_ASSERT_NEXT(a_end, clk, rst_n, out_valid && out_ready && last_word,
                     !out_valid, "stream continued past last word")
endmodule

bind scrypt_romix_salsa20_8 srx_checker u_chk (.*);

// ===== dv/scrypt_romix_salsa20_8_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrypt_romix_salsa20_8_test
// Self-checking bench for the ROMix (r=1) block: loads 32-word blocks under a
// range of cost settings, mirrors ROMix with its own Salsa20/8 model and
// checks every output word and its last flag in order. The sender works in
// bursts and the receiver stalls on a rotating pattern.
// ----------------------------------------------------------------------------
module scrypt_romix_salsa20_8_test;
    import srx_pkg::*;

    typedef logic [31:0] salsa_state_t [16];

    typedef struct {
        logic [31:0] word;
        logic        last;
    } out_word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [COST_W-1:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] data_word;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] result_word;
    logic        last_word;

    // predictor state
    logic [31:0] mix_blk [32];
    logic [31:0] pad_mem [1 << (MAX_COST_LOG2 + 5)];
    int unsigned words_loaded;
    int unsigned cost_setting;

    out_word_t   mixed_words_q [$];
    int unsigned fail_count;
    int unsigned words_sent;
    int unsigned words_seen;
    int unsigned blocks_done;
    int unsigned burst_left;
    int unsigned rx_cycle;

    // directed words: extremes, single-bit and other bit patterns
    logic [31:0] corner_words [24] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
        32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555,
        32'h0000_FFFF, 32'hFFFF_0000, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
        32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'h0000_03FF, 32'h8000_0001, 32'h0123_4567, 32'h89AB_CDEF,
        32'hDEAD_BEEF, 32'h0000_0002, 32'h4000_0000, 32'hFFFF_FC00
    };

    // cost for each block; the first runs at the reset value
    int unsigned block_costs [9] = '{10, 0, 15, 1, 2, 3, 4, 5, 1};

    scrypt_romix_salsa20_8 dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_word   (data_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_word (result_word),
        .last_word   (last_word)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic salsa_state_t quarter(input salsa_state_t x, input int a,
                                             input int b, input int c, input int d);
        x[b] = x[b] ^ rol32(x[a] + x[d], 7);
        x[c] = x[c] ^ rol32(x[b] + x[a], 9);
        x[d] = x[d] ^ rol32(x[c] + x[b], 13);
        x[a] = x[a] ^ rol32(x[d] + x[c], 18);
        return x;
    endfunction

    // half at dst = Salsa20/8(dst ^ src) + (dst ^ src)
    task automatic salsa_xor_half(input int dst, input int src);
        salsa_state_t x;
        for (int i = 0; i < 16; i++)
        begin
            mix_blk[dst + i] = mix_blk[dst + i] ^ mix_blk[src + i];
            x[i] = mix_blk[dst + i];
        end
        for (int r = 0; r < 4; r++)
        begin
            x = quarter(x, 0, 4, 8, 12);
            x = quarter(x, 5, 9, 13, 1);
            x = quarter(x, 10, 14, 2, 6);
            x = quarter(x, 15, 3, 7, 11);
            x = quarter(x, 0, 1, 2, 3);
            x = quarter(x, 5, 6, 7, 4);
            x = quarter(x, 10, 11, 8, 9);
            x = quarter(x, 15, 12, 13, 14);
        end
        for (int i = 0; i < 16; i++)
            mix_blk[dst + i] = mix_blk[dst + i] + x[i];
    endtask

    task automatic block_mix();
        salsa_xor_half(0, 16);
        salsa_xor_half(16, 0);
    endtask

    // run both ROMix phases on the collected block and queue the output
    task automatic romix_predict();
        int unsigned lg;
        int unsigned n;
        int unsigned ent;
        lg = (cost_setting > MAX_COST_LOG2) ? MAX_COST_LOG2 : cost_setting;
        n = 1 << lg;
        for (int unsigned i = 0; i < n; i++)
        begin
            for (int k = 0; k < 32; k++)
                pad_mem[i * 32 + k] = mix_blk[k];
            block_mix();
        end
        for (int unsigned i = 0; i < n; i++)
        begin
            ent = mix_blk[16] & (n - 1);
            for (int k = 0; k < 32; k++)
                mix_blk[k] = mix_blk[k] ^ pad_mem[ent * 32 + k];
            block_mix();
        end
        for (int k = 0; k < 32; k++)
            mixed_words_q.push_back('{word: mix_blk[k], last: (k == 31)});
    endtask

    task automatic write_cost(input int unsigned value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value[COST_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        cost_setting = value;
    endtask

    // send one request in bursts with random gaps, predicting once a block is complete;
    // called at a rising edge, returns at the accepting edge
    task automatic send_word(input logic [31:0] w);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        data_word <= w;
        do
            @(posedge clk);
        while (!in_ready);
        mix_blk[words_loaded] = w;
        words_loaded = (words_loaded + 1) % 32;
        words_sent++;
        if (words_loaded == 0)
            romix_predict();
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // check output and stall the receiver on a rotating pattern
    always @(posedge clk)
    begin
        out_word_t exp_w;
        if (rst_n)
        begin
            rx_cycle <= rx_cycle + 1;
            case ((rx_cycle >> 6) % 3)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 1);
                default: out_ready <= (rx_cycle % 5) != 0;
            endcase
            if (out_valid && out_ready)
            begin
                words_seen++;
                if (mixed_words_q.size() == 0)
                begin
                    $error("unexpected output word %h", result_word);
                    fail_count++;
                end
                else
                begin
                    exp_w = mixed_words_q.pop_front();
                    if (result_word !== exp_w.word)
                    begin
                        $error("result_word: expected %h, got %h", exp_w.word, result_word);
                        fail_count++;
                    end
                    if (last_word !== exp_w.last)
                    begin
                        $error("last_word: expected %b, got %b", exp_w.last, last_word);
                        fail_count++;
                    end
                    if (exp_w.last)
                        blocks_done++;
                end
            end
        end
    end

    // hard stop for a hung run
    initial
    begin
        #40ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        data_word = '0;
        out_ready = 1'b0;
        fail_count = 0;
        words_sent = 0;
        words_seen = 0;
        blocks_done = 0;
        burst_left = 0;
        rx_cycle = 0;
        words_loaded = 0;
        cost_setting = 10;
        for (int k = 0; k < 32; k++)
            mix_blk[k] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int b = 0; b < 9; b++)
        begin
            // change the cost only while the block is idle
            if (b != 0)
                write_cost(block_costs[b]);
            for (int w = 0; w < 32; w++)
            begin
                if (b == 0 && w < 24)
                    send_word(corner_words[w]);
                else
                    send_word(random_word());
            end
            in_valid <= 1'b0;
            while (mixed_words_q.size() != 0)
                @(posedge clk);
            repeat (8) @(posedge clk);
        end

        // drain and let any stray output show up
        while (mixed_words_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Sent %0d words in %0d blocks, checked %0d output words.",
                 words_sent, blocks_done, words_seen);
        $display("Costs covered: reset value, zero, saturated 15, and 1 to 5.");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
